// ===== rtl/core/nes_pkg.sv =====
// shared types, character codes and frequency table for the note event stream sequencer
package nes_pkg;

    typedef enum logic [1:0] {
        KIND_TONE    = 2'd0,
        KIND_SILENCE = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    localparam logic [7:0] CHAR_BAR   = 8'h7C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int          NOTE_W   = 7;
    localparam int          FREQ_W   = 14;
    localparam int          DUR_W    = 32;
    localparam int          TIME_W   = 64;
    localparam logic [10:0] NOTE_MAX = 11'd127;
    localparam logic [35:0] DUR_MAX  = 36'h0_FFFF_FFFF;

    // command from the parser to the event stage
    typedef struct packed {
        kind_t              kind;
        logic [NOTE_W-1:0]  note;
        logic [DUR_W-1:0]   dur;
        logic               add_end;
    } cmd_t;

    // one result item
    typedef struct packed {
        kind_t              kind;
        logic [FREQ_W-1:0]  freq;
        logic [TIME_W-1:0]  start;
        logic [DUR_W-1:0]   dur;
        logic               last;
    } res_t;

    localparam logic [FREQ_W-1:0] FREQ_ROM [128] = '{
        14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
        14'd12, 14'd13, 14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
        14'd20, 14'd21, 14'd23, 14'd24, 14'd25, 14'd27, 14'd29, 14'd30,
        14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
        14'd51, 14'd55, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
        14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd110, 14'd116, 14'd123,
        14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
        14'd207, 14'd220, 14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311,
        14'd329, 14'd349, 14'd369, 14'd391, 14'd415, 14'd440, 14'd466, 14'd493,
        14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
        14'd830, 14'd880, 14'd932, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244,
        14'd1318, 14'd1396, 14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
        14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959, 14'd3135,
        14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978,
        14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
        14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839, 14'd12543
    };

    function automatic logic [FREQ_W-1:0] freq_lookup(input logic [NOTE_W-1:0] note);
        return FREQ_ROM[note];
    endfunction

endpackage

// ===== rtl/core/nes_fifo.sv =====
// small register queue used between the parser and event stage and on the result side
module nes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/nes_front.sv =====
// byte parser: tracks note and duration fields and issues event commands
module nes_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_take,
    input  logic [7:0]     song_byte,
    input  logic           song_last,
    output logic           cmd_push,
    output nes_pkg::cmd_t  cmd
);

    logic                       in_dur_reg, in_dur_next;
    logic [nes_pkg::NOTE_W-1:0] note_reg, note_next;
    logic                       note_big_reg, note_big_next;
    logic                       note_has_reg, note_has_next;
    logic                       note_stop_reg, note_stop_next;
    logic                       silence_reg, silence_next;
    logic [1:0]                 char_cnt_reg, char_cnt_next;
    logic [nes_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic                       dur_has_reg, dur_has_next;
    logic                       dur_stop_reg, dur_stop_next;
    logic                       done_reg, done_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic        is_bar;
    logic        ok;
    logic [10:0] note_acc;
    logic [35:0] dur_acc;

    assign is_digit = (song_byte >= nes_pkg::CHAR_ZERO) && (song_byte <= nes_pkg::CHAR_NINE);
    assign digit    = 4'(song_byte - nes_pkg::CHAR_ZERO);
    assign is_bar   = (song_byte == nes_pkg::CHAR_BAR) && (in_dur_reg || char_cnt_reg != 2'd0);
    assign ok       = in_dur_reg && dur_has_reg &&
                      (silence_reg || (note_has_reg && !note_big_reg));
    assign note_acc = {1'b0, note_reg, 3'b000} + {3'b000, note_reg, 1'b0} + {7'd0, digit};
    assign dur_acc  = {1'b0, dur_reg, 3'b000} + {3'b000, dur_reg, 1'b0} + {32'd0, digit};

    always_comb
    begin
        in_dur_next    = in_dur_reg;
        note_next      = note_reg;
        note_big_next  = note_big_reg;
        note_has_next  = note_has_reg;
        note_stop_next = note_stop_reg;
        silence_next   = silence_reg;
        char_cnt_next  = char_cnt_reg;
        dur_next       = dur_reg;
        dur_has_next   = dur_has_reg;
        dur_stop_next  = dur_stop_reg;
        done_next      = done_reg;
        cmd_push       = 1'b0;
        cmd.kind       = nes_pkg::KIND_END;
        cmd.note       = note_reg;
        cmd.dur        = dur_reg;
        cmd.add_end    = 1'b0;

        if (in_take && !done_reg)
        begin
            if (is_bar)
            begin
                cmd_push = 1'b1;
                if (ok)
                begin
                    cmd.kind       = silence_reg ? nes_pkg::KIND_SILENCE : nes_pkg::KIND_TONE;
                    cmd.add_end    = song_last;
                    done_next      = song_last;
                    in_dur_next    = 1'b0;
                    note_next      = '0;
                    note_big_next  = 1'b0;
                    note_has_next  = 1'b0;
                    note_stop_next = 1'b0;
                    silence_next   = 1'b0;
                    char_cnt_next  = 2'd0;
                    dur_next       = '0;
                    dur_has_next   = 1'b0;
                    dur_stop_next  = 1'b0;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            else
            begin
                if (!in_dur_reg)
                begin
                    if (song_byte == nes_pkg::CHAR_COLON)
                    begin
                        in_dur_next = 1'b1;
                    end
                    else
                    begin
                        silence_next = (char_cnt_reg == 2'd0) && (song_byte == nes_pkg::CHAR_X);
                        if (char_cnt_reg != 2'd2)
                        begin
                            char_cnt_next = char_cnt_reg + 1'b1;
                        end
                        if (!note_stop_reg)
                        begin
                            if (!is_digit)
                            begin
                                note_stop_next = 1'b1;
                            end
                            else
                            begin
                                note_has_next = 1'b1;
                                if (!note_big_reg)
                                begin
                                    if (note_acc > nes_pkg::NOTE_MAX)
                                    begin
                                        note_big_next = 1'b1;
                                    end
                                    else
                                    begin
                                        note_next = note_acc[nes_pkg::NOTE_W-1:0];
                                    end
                                end
                            end
                        end
                    end
                end
                else if (!dur_stop_reg)
                begin
                    if (!is_digit)
                    begin
                        dur_stop_next = 1'b1;
                    end
                    else
                    begin
                        dur_has_next = 1'b1;
                        dur_next     = (dur_acc > nes_pkg::DUR_MAX) ?
                                       nes_pkg::DUR_MAX[nes_pkg::DUR_W-1:0] :
                                       dur_acc[nes_pkg::DUR_W-1:0];
                    end
                end
                if (song_last)
                begin
                    cmd_push  = 1'b1;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dur_reg    <= 1'b0;
            note_reg      <= '0;
            note_big_reg  <= 1'b0;
            note_has_reg  <= 1'b0;
            note_stop_reg <= 1'b0;
            silence_reg   <= 1'b0;
            char_cnt_reg  <= 2'd0;
            dur_reg       <= '0;
            dur_has_reg   <= 1'b0;
            dur_stop_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_dur_reg    <= in_dur_next;
            note_reg      <= note_next;
            note_big_reg  <= note_big_next;
            note_has_reg  <= note_has_next;
            note_stop_reg <= note_stop_next;
            silence_reg   <= silence_next;
            char_cnt_reg  <= char_cnt_next;
            dur_reg       <= dur_next;
            dur_has_reg   <= dur_has_next;
            dur_stop_reg  <= dur_stop_next;
            done_reg      <= done_next;
        end
    end

endmodule

// ===== rtl/core/nes_back.sv =====
// event stage: frequency lookup, start time and result generation
module nes_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nes_pkg::TIME_W-1:0]  song_start,
    input  logic                        cmd_empty,
    input  nes_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    input  logic                        res_full,
    output logic                        res_push,
    output nes_pkg::res_t               res
);

    logic                        pend_end_reg, pend_end_next;
    logic [nes_pkg::TIME_W-1:0]  offset_reg, offset_next;
    logic                        go;

    assign go       = !cmd_empty && !res_full;
    assign res_push = go;

    always_comb
    begin
        pend_end_next = pend_end_reg;
        offset_next   = offset_reg;
        cmd_pop       = 1'b0;
        res.start     = song_start + offset_reg;
        res.kind      = nes_pkg::KIND_END;
        res.freq      = '0;
        res.dur       = '0;
        res.last      = 1'b1;
        if (pend_end_reg || cmd.kind == nes_pkg::KIND_END)
        begin
            if (go)
            begin
                cmd_pop       = 1'b1;
                pend_end_next = 1'b0;
            end
        end
        else
        begin
            res.kind = cmd.kind;
            res.freq = (cmd.kind == nes_pkg::KIND_TONE) ? nes_pkg::freq_lookup(cmd.note) : '0;
            res.dur  = cmd.dur;
            res.last = !cmd.add_end;
            if (go)
            begin
                offset_next   = offset_reg + {32'd0, cmd.dur};
                cmd_pop       = !cmd.add_end;
                pend_end_next = cmd.add_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_end_reg <= 1'b0;
            offset_reg   <= '0;
        end
        else
        begin
            pend_end_reg <= pend_end_next;
            offset_reg   <= offset_next;
        end
    end

`ifndef SYNTHESIS
    a_pend_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pend_end_reg |-> !cmd_empty)
        else $error("pending end without a command");
    a_pend_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pend_end_reg && !res_full |=> !pend_end_reg)
        else $error("pending end not retired");
    a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !res_push |=> $stable(offset_reg))
        else $error("offset moved without a result");
    a_pop_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> res_push && res.last)
        else $error("command popped before its final result");
`endif

endmodule

// ===== rtl/core/note_event_stream_sequencer.sv =====
// top level of the note event stream sequencer
// usage:
//   song text goes in one byte per transfer on push/full (song_byte, song_last);
//   events come out on empty/pop as event_kind, frequency_hz, start_us,
//   duration_us and last_in_run, oldest first
//   song_start_us is loaded via cfg_valid/cfg_ready; the user must write it only
//   while the block is idle (not enforced by the block); cfg_ready is always high
// timing:
//   one byte accepted per cycle while full is low; a closing bar or final byte
//   writes its command into the command queue when it is taken, and the event
//   stage moves its result into the result queue, whose head drives the ports
//   the event stage retires one result per cycle while the result queue has
//   room, so a byte that gives a tone plus the song end yields two results
// reset:
//   clears the parser, the time offset, both queues and song_start_us
// stalls:
//   when pop is held low the result queue fills, the event stage waits, the
//   command queue fills and full rises; plain text bytes keep flowing until then
module note_event_stream_sequencer #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  song_byte,
    input  logic        song_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_kind,
    output logic [13:0] frequency_hz,
    output logic [63:0] start_us,
    output logic [31:0] duration_us,
    output logic        last_in_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] song_start_us
);

    localparam int CMD_W = $bits(nes_pkg::cmd_t);
    localparam int RES_W = $bits(nes_pkg::res_t);

    logic [63:0]          song_start_reg;
    logic                 in_take;
    logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
    nes_pkg::cmd_t        cmd_in, cmd_out;
    logic [CMD_W-1:0]     cmd_rd;
    logic                 res_push, res_full;
    nes_pkg::res_t        res_in, res_out;
    logic [RES_W-1:0]     res_rd;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign in_take   = push && !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            song_start_reg <= song_start_us;
        end
    end

    nes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .song_byte (song_byte),
        .song_last (song_last),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    nes_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    assign cmd_out = nes_pkg::cmd_t'(cmd_rd);

    nes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .song_start (song_start_reg),
        .cmd_empty  (cmd_empty),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    nes_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_out      = nes_pkg::res_t'(res_rd);
    assign event_kind   = res_out.kind;
    assign frequency_hz = res_out.freq;
    assign start_us     = res_out.start;
    assign duration_us  = res_out.dur;
    assign last_in_run  = res_out.last;

endmodule

// ===== sim/note_event_stream_sequencer_test.sv =====
// self-checking testbench for the note event stream sequencer: byte stream in, tone, silence and end events out
`timescale 1ns / 1ps

module note_event_stream_sequencer_test;

    localparam int TOP_NOTE   = 127;
    localparam int HOLD_OFF   = 300;
    localparam int SETTLE     = 10;
    localparam int PHASE_SIZE = 130;

    class song_timeline;
        nes_pkg::res_t pending_events[$];
        logic [63:0]   base_us;
        logic [63:0]   offset_us;
        logic [13:0]   pitch_hz[128];
        bit            in_dur;
        logic [7:0]    note_val;
        bit            note_big;
        bit            note_dig;
        bit            note_stop;
        bit            note_silent;
        logic [1:0]    char_cnt;
        logic [31:0]   dur_val;
        bit            dur_dig;
        bit            dur_stop;
        bit            finished;
        int            faults;

        function new();
            for (int i = 0; i < 128; i++)
            begin
                pitch_hz[i] = 14'($rtoi(440.0 * 2.0 ** ((i - 69) / 12.0) + 1.0e-6));
            end
            base_us = '0;
            offset_us = '0;
            finished = 1'b0;
            faults = 0;
            clear_event();
        endfunction

        function void clear_event();
            in_dur = 1'b0;
            note_val = '0;
            note_big = 1'b0;
            note_dig = 1'b0;
            note_stop = 1'b0;
            note_silent = 1'b0;
            char_cnt = '0;
            dur_val = '0;
            dur_dig = 1'b0;
            dur_stop = 1'b0;
        endfunction

        function void take_byte(input logic [7:0] b, input bit fin);
            nes_pkg::res_t outs[2];
            int            n = 0;
            bit            digit;
            logic [3:0]    dv;
            logic [10:0]   nv;
            logic [35:0]   wide;
            logic [63:0]   at;
            bit            ok;
            if (finished)
            begin
                return;
            end
            digit = (b >= nes_pkg::CHAR_ZERO) && (b <= nes_pkg::CHAR_NINE);
            dv = 4'(b - nes_pkg::CHAR_ZERO);
            at = base_us + offset_us;
            if (b == nes_pkg::CHAR_BAR && (in_dur || char_cnt != 0))
            begin
                ok = in_dur && dur_dig && (note_silent || (note_dig && !note_big));
                if (ok)
                begin
                    outs[n].kind = note_silent ? nes_pkg::KIND_SILENCE : nes_pkg::KIND_TONE;
                    outs[n].freq = note_silent ? 14'd0 : pitch_hz[note_val[6:0]];
                    outs[n].start = at;
                    outs[n].dur = dur_val;
                    outs[n].last = 1'b0;
                    n++;
                    offset_us = offset_us + 64'(dur_val);
                    clear_event();
                end
                else
                begin
                    outs[n] = '{kind: nes_pkg::KIND_END, freq: '0, start: at, dur: '0,
                                last: 1'b0};
                    n++;
                    finished = 1'b1;
                end
            end
            else if (!in_dur)
            begin
                if (b == nes_pkg::CHAR_COLON)
                begin
                    in_dur = 1'b1;
                end
                else
                begin
                    note_silent = (char_cnt == 0) && (b == nes_pkg::CHAR_X);
                    if (char_cnt < 2)
                    begin
                        char_cnt++;
                    end
                    if (!note_stop)
                    begin
                        if (!digit)
                        begin
                            note_stop = 1'b1;
                        end
                        else
                        begin
                            note_dig = 1'b1;
                            if (!note_big)
                            begin
                                nv = 11'(note_val) * 11'd10 + 11'(dv);
                                if (nv > TOP_NOTE)
                                begin
                                    note_big = 1'b1;
                                end
                                else
                                begin
                                    note_val = nv[7:0];
                                end
                            end
                        end
                    end
                end
            end
            else if (!dur_stop)
            begin
                if (!digit)
                begin
                    dur_stop = 1'b1;
                end
                else
                begin
                    dur_dig = 1'b1;
                    wide = 36'(dur_val) * 36'd10 + 36'(dv);
                    dur_val = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
                end
            end
            if (fin && !finished)
            begin
                outs[n] = '{kind: nes_pkg::KIND_END, freq: '0, start: base_us + offset_us,
                            dur: '0, last: 1'b0};
                n++;
                finished = 1'b1;
            end
            if (n > 0)
            begin
                outs[n - 1].last = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                pending_events.push_back(outs[i]);
            end
        endfunction

        function void match_event(input nes_pkg::res_t got);
            nes_pkg::res_t want;
            if (pending_events.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("unexpected event: kind %0d freq %0d start %0d dur %0d last %0d",
                             got.kind, got.freq, got.start, got.dur, got.last);
                end
                return;
            end
            want = pending_events.pop_front();
            if (got.kind != want.kind || got.freq != want.freq || got.start != want.start ||
                got.dur != want.dur || got.last != want.last)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("mismatch: expected kind %0d freq %0d start %0d dur %0d last %0d",
                             want.kind, want.freq, want.start, want.dur, want.last);
                    $display("          actual   kind %0d freq %0d start %0d dur %0d last %0d",
                             got.kind, got.freq, got.start, got.dur, got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  song_byte;
    logic        song_last;
    logic        empty;
    logic        pop;
    logic [1:0]  event_kind;
    logic [13:0] frequency_hz;
    logic [63:0] start_us;
    logic [31:0] duration_us;
    logic        last_in_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] song_start_us;

    song_timeline timeline;
    logic [7:0]   song_text[$];
    int           burst_left;
    bit           hold_req;

    note_event_stream_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .song_byte     (song_byte),
        .song_last     (song_last),
        .empty         (empty),
        .pop           (pop),
        .event_kind    (event_kind),
        .frequency_hz  (frequency_hz),
        .start_us      (start_us),
        .duration_us   (duration_us),
        .last_in_run   (last_in_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .song_start_us (song_start_us)
    );

    always #2 clk = ~clk;

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            song_text.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] junk_char(input bit colon_ok);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == nes_pkg::CHAR_BAR || (!colon_ok && c == nes_pkg::CHAR_COLON));
        return c;
    endfunction

    // trailing text after a number: starts with a non-digit
    function automatic void add_junk(input bit colon_ok);
        logic [7:0] c;
        int         extra;
        do
        begin
            c = junk_char(colon_ok);
        end
        while (c >= nes_pkg::CHAR_ZERO && c <= nes_pkg::CHAR_NINE);
        song_text.push_back(c);
        extra = $urandom_range(0, 3);
        for (int i = 0; i < extra; i++)
        begin
            song_text.push_back(junk_char(colon_ok));
        end
    endfunction

    function automatic void add_note();
        int pick;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
        begin
            add_str("0");
        end
        add_str($sformatf("%0d", (pick == 0) ? 0 : (pick == 1) ? TOP_NOTE :
                                 $urandom_range(0, TOP_NOTE)));
    endfunction

    function automatic void add_event();
        int          pick;
        logic [63:0] span;
        if ($urandom_range(0, 6) == 0)
        begin
            add_str("X");
        end
        else
        begin
            add_note();
            if ($urandom_range(0, 3) == 0)
            begin
                add_junk(1'b0);
            end
        end
        song_text.push_back(nes_pkg::CHAR_COLON);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            span = '0;
        end
        else if (pick <= 5)
        begin
            span = $urandom_range(0, 99999);
        end
        else if (pick <= 8)
        begin
            span = 64'($urandom);
        end
        else
        begin
            span = {$urandom, $urandom};
        end
        if ($urandom_range(0, 7) == 0)
        begin
            add_str("00");
        end
        add_str($sformatf("%0d", span));
        if ($urandom_range(0, 3) == 0)
        begin
            add_junk(1'b1);
        end
        song_text.push_back(nes_pkg::CHAR_BAR);
    endfunction

    task automatic offer_byte(input logic [7:0] b, input bit fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        song_byte <= b;
        song_last <= fin;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        timeline.take_byte(b, fin);
    endtask

    task automatic play_text(input bit fin_at_end);
        for (int i = 0; i < song_text.size(); i++)
        begin
            offer_byte(song_text[i], fin_at_end && (i == song_text.size() - 1));
        end
        song_text.delete();
    endtask

    task automatic settle_out(input int extra);
        push <= 1'b0;
        burst_left = 0;
        while (timeline.pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic load_start(input logic [63:0] v);
        song_start_us <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        timeline.base_us = v;
    endtask

    // receiver: stretches of steady, random and sparse pops, plus one long hold-off
    initial
    begin : sink
        nes_pkg::res_t seen;
        int            mode;
        int            mode_left;
        int            hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.kind = nes_pkg::kind_t'(event_kind);
                seen.freq = frequency_hz;
                seen.start = start_us;
                seen.dur = duration_us;
                seen.last = last_in_run;
                timeline.match_event(seen);
            end
            if (hold_req)
            begin
                hold_left = HOLD_OFF;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(1, 40);
                end
                mode_left--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] bases[6];
        int          ending;
        int          variant;
        timeline = new();
        rst_n = 1'b0;
        push = 1'b0;
        song_byte = '0;
        song_last = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        song_start_us = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_start(64'd0);

        // lowest note and duration, highest note with saturating duration, silence,
        // trailing text after both numbers with a second colon in the duration
        add_str("0:0|");
        add_str("127:9999999999|");
        add_str("X:5|");
        add_str("69");
        song_text.push_back(8'hFF);
        add_str(":7:");
        song_text.push_back(8'h00);
        song_text.push_back(nes_pkg::CHAR_BAR);
        play_text(1'b0);
        settle_out(SETTLE);

        bases[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        bases[1] = {$urandom, $urandom};
        bases[2] = 64'hFFFF_FFFF_FFFF_FC00;
        bases[3] = 64'd0;
        bases[4] = 64'($urandom);
        bases[5] = {$urandom, $urandom};
        for (int p = 0; p < 6; p++)
        begin
            load_start(bases[p]);
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            while (song_text.size() < PHASE_SIZE)
            begin
                add_event();
            end
            play_text(1'b0);
            settle_out(SETTLE);
        end

        // the song ends only once per reset: pick one way to end it
        ending = $urandom_range(0, 2);
        if (ending == 0)
        begin
            add_event();
            play_text(1'b1);
        end
        else if (ending == 1)
        begin
            add_note();
            if ($urandom_range(0, 1) == 0)
            begin
                song_text.push_back(nes_pkg::CHAR_COLON);
                add_str($sformatf("%0d", $urandom_range(0, 999)));
            end
            song_text.push_back(junk_char(1'b1));
            play_text(1'b1);
        end
        else
        begin
            variant = $urandom_range(0, 4);
            case (variant)
                0:
                begin
                    song_text.push_back(nes_pkg::CHAR_BAR);
                    add_str("5:5|");
                end
                1: add_str($sformatf("%0d|", $urandom_range(0, TOP_NOTE)));
                2: add_str($sformatf("%0d:5|", $urandom_range(TOP_NOTE + 1, 999)));
                3: add_str("XY:5|");
                default:
                begin
                    add_str($sformatf("%0d:", $urandom_range(0, TOP_NOTE)));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        add_junk(1'b1);
                    end
                    song_text.push_back(nes_pkg::CHAR_BAR);
                end
            endcase
            play_text(1'b0);
        end

        // bytes after the end of the song must be ignored
        for (int i = 0; i < 8; i++)
        begin
            offer_byte(($urandom_range(0, 2) == 0) ? nes_pkg::CHAR_BAR :
                                                     8'($urandom_range(0, 255)),
                       (i == 7) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        settle_out(4 * SETTLE);

        if (timeline.faults == 0 && timeline.pending_events.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/nes_pkg.sv
rtl/core/nes_fifo.sv
rtl/core/nes_front.sv
rtl/core/nes_back.sv
rtl/core/note_event_stream_sequencer.sv
sim/note_event_stream_sequencer_test.sv
